>>> rtl/gftc_pkg.sv
package gftc_pkg;

   // Angle constants in Q5.13
   localparam logic signed [17:0] PI_Q13      = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

   // CORDIC datapath widths and constants in Q.30
   localparam int CW = 33;
   localparam int ZW = 34;
   localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

   // Reduction divisor 50 * 2^16: round offset and reciprocal for t / 50
   localparam logic [48:0] RED_ROUND = 49'd1638400;
   localparam logic [31:0] RECIP_50  = 32'd2748779070;

   // Register indexes
   localparam logic [2:0] CSR_STEER_GAIN_LAT = 3'd0;
   localparam logic [2:0] CSR_STEER_GAIN_HDG = 3'd1;
   localparam logic [2:0] CSR_SPEED_GAIN_LAT = 3'd2;
   localparam logic [2:0] CSR_SPEED_GAIN_HDG = 3'd3;
   localparam logic [2:0] CSR_MAX_SPEED      = 3'd4;
   localparam logic [2:0] CSR_BASE_SPEED     = 3'd5;

   // Status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CROSSED = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;

   typedef struct packed {
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic signed [31:0] pose_z;
      logic signed [15:0] pose_yaw;
      logic signed [15:0] pose_pitch;
      logic signed [15:0] pose_roll;
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic signed [31:0] goal_z;
      logic signed [15:0] goal_yaw;
      logic signed [15:0] goal_pitch;
      logic signed [15:0] goal_roll;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] steering_cmd;
      logic signed [15:0] speed_cmd;
      logic signed [31:0] lateral_error;
      logic signed [15:0] heading_error;
      logic signed [31:0] along_goal_x;
   } rsp_type;

   // Arctangent of 2^-i in Q.30
   function automatic logic [30:0] atan_q30(input int i);
      case (i)
         0:  return 31'd843314857;
         1:  return 31'd497837829;
         2:  return 31'd263043837;
         3:  return 31'd133525159;
         4:  return 31'd67021687;
         5:  return 31'd33543516;
         6:  return 31'd16775851;
         7:  return 31'd8388437;
         8:  return 31'd4194283;
         9:  return 31'd2097149;
         10: return 31'd1048576;
         11: return 31'd524288;
         12: return 31'd262144;
         13: return 31'd131072;
         14: return 31'd65536;
         15: return 31'd32768;
         16: return 31'd16384;
         17: return 31'd8192;
         18: return 31'd4096;
         19: return 31'd2048;
         20: return 31'd1024;
         21: return 31'd512;
         22: return 31'd256;
         23: return 31'd128;
         default: return 31'd0;
      endcase
   endfunction

endpackage

>>> rtl/gftc_cordic.sv
module gftc_cordic import gftc_pkg::*; #(
   parameter int ITERS = 16
) (
   input  logic                 clock,
   input  logic [ITERS-1:0]     stage_en,
   input  logic signed [ZW-1:0] z_in,
   input  logic                 neg_in,
   output logic signed [CW-1:0] sin_out,
   output logic signed [CW-1:0] cos_out
);

   logic signed [CW-1:0] x_ff [ITERS];
   logic signed [CW-1:0] y_ff [ITERS];
   logic signed [ZW-1:0] z_ff [ITERS];
   logic                 neg_ff [ITERS];

   // One rotation step per stage
   for (genvar i = 0; i < ITERS; i++) begin : g_step
      logic signed [CW-1:0] x_prev;
      logic signed [CW-1:0] y_prev;
      logic signed [ZW-1:0] z_prev;
      logic                 neg_prev;
      logic signed [ZW-1:0] atan_val;

      if (i == 0) begin : g_first
         assign x_prev   = CORDIC_GAIN;
         assign y_prev   = '0;
         assign z_prev   = z_in;
         assign neg_prev = neg_in;
      end else begin : g_next
         assign x_prev   = x_ff[i-1];
         assign y_prev   = y_ff[i-1];
         assign z_prev   = z_ff[i-1];
         assign neg_prev = neg_ff[i-1];
      end

      assign atan_val = $signed(ZW'(atan_q30(i)));

      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            neg_ff[i] <= neg_prev;
            if (z_prev >= 0) begin
               x_ff[i] <= x_prev - (y_prev >>> i);
               y_ff[i] <= y_prev + (x_prev >>> i);
               z_ff[i] <= z_prev - atan_val;
            end else begin
               x_ff[i] <= x_prev + (y_prev >>> i);
               y_ff[i] <= y_prev - (x_prev >>> i);
               z_ff[i] <= z_prev + atan_val;
            end
         end
      end
   end

   // Undo the half-turn fold
   assign sin_out = neg_ff[ITERS-1] ? -y_ff[ITERS-1] : y_ff[ITERS-1];
   assign cos_out = neg_ff[ITERS-1] ? -x_ff[ITERS-1] : x_ff[ITERS-1];

endmodule

>>> rtl/goal_frame_path_tracking_controller_core.sv
// Stages in order: stage 0, the CORDIC steps, P1 to P7 and the output register.
// Throughput: one beat per cycle; every stage holds its own valid bit, so a
// stalled response only blocks stages that are full behind it.
// The pipelined CORDIC takes one rotation step per stage.
// Reset is synchronous and active high: clears all valid bits and the gain and speed registers.
module goal_frame_path_tracking_controller_core import gftc_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int N     = CORDIC_ITERATIONS;
   localparam int ST_P1 = N + 1;
   localparam int ST_P2 = N + 2;
   localparam int ST_P3 = N + 3;
   localparam int ST_P4 = N + 4;
   localparam int ST_P5 = N + 5;
   localparam int ST_P6 = N + 6;
   localparam int ST_P7 = N + 7;
   localparam int ST_OUT = N + 8;
   localparam int NS    = N + 9;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
      logic signed [15:0] head;
   } carry_type;

   function automatic logic signed [17:0] wrap(input logic signed [17:0] a);
      if (a > PI_Q13) return a - TWO_PI_Q13;
      if (a < -PI_Q13) return a + TWO_PI_Q13;
      return a;
   endfunction

   // {fold flag, folded angle in Q.30}
   function automatic logic [ZW:0] prep_angle(input logic signed [15:0] a);
      logic signed [ZW-1:0] z;
      z = {a[15], a, 17'b0};
      if (z > HALF_PI_Q30) return {1'b1, z - PI_Q30};
      if (z < -HALF_PI_Q30) return {1'b1, z + PI_Q30};
      return {1'b0, z};
   endfunction

   function automatic logic signed [32:0] mul30(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b) + 66'sd536870912;
      return p[62:30];
   endfunction

   function automatic logic signed [35:0] term30(input logic signed [32:0] m,
                                                 input logic signed [32:0] d);
      logic signed [65:0] p;
      p = 66'(m) * 66'(d) + 66'sd536870912;
      return p[65:30];
   endfunction

   // Registers
   logic signed [15:0] steer_gain_lat_ff, steer_gain_hdg_ff;
   logic signed [15:0] speed_gain_lat_ff, speed_gain_hdg_ff;
   logic signed [15:0] max_speed_ff, base_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         steer_gain_lat_ff <= '0;
         steer_gain_hdg_ff <= '0;
         speed_gain_lat_ff <= '0;
         speed_gain_hdg_ff <= '0;
         max_speed_ff      <= '0;
         base_speed_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEER_GAIN_LAT: steer_gain_lat_ff <= csr_wdata;
            CSR_STEER_GAIN_HDG: steer_gain_hdg_ff <= csr_wdata;
            CSR_SPEED_GAIN_LAT: speed_gain_lat_ff <= csr_wdata;
            CSR_SPEED_GAIN_HDG: speed_gain_hdg_ff <= csr_wdata;
            CSR_MAX_SPEED:      max_speed_ff      <= csr_wdata;
            CSR_BASE_SPEED:     base_speed_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage enables: a stage loads when empty or when its successor moves on
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] stage_en;

   always_comb begin
      stage_en[NS-1] = !v_ff[NS-1] || rsp_ready;
      for (int j = NS - 2; j >= 0; j--) begin
         stage_en[j] = !v_ff[j] || stage_en[j+1];
      end
   end

   assign v_in      = {v_ff[NS-2:0], req_valid};
   assign req_ready = stage_en[0];
   assign rsp_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int j = 0; j < NS; j++) begin
            if (stage_en[j]) v_ff[j] <= v_in[j];
         end
      end
   end

   // Stage 0: offsets, heading error, angle folding
   carry_type            carry_in;
   carry_type            carry_s0_ff;
   logic signed [17:0]   head_wide;
   logic [ZW:0]          prep_yaw, prep_pitch, prep_roll;
   logic signed [ZW-1:0] z_yaw_ff, z_pitch_ff, z_roll_ff;
   logic                 n_yaw_ff, n_pitch_ff, n_roll_ff;

   always_comb begin
      carry_in.dx = 33'(req.pose_x) - 33'(req.goal_x);
      carry_in.dy = 33'(req.pose_y) - 33'(req.goal_y);
      carry_in.dz = 33'(req.pose_z) - 33'(req.goal_z);
      head_wide = wrap(wrap(18'(req.pose_yaw)) - 18'(req.goal_yaw));
      if (head_wide > 18'sd32767) carry_in.head = 16'sh7fff;
      else if (head_wide < -18'sd32768) carry_in.head = 16'sh8000;
      else carry_in.head = head_wide[15:0];
      prep_yaw   = prep_angle(req.goal_yaw);
      prep_pitch = prep_angle(req.goal_pitch);
      prep_roll  = prep_angle(req.goal_roll);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         carry_s0_ff <= carry_in;
         z_yaw_ff    <= prep_yaw[ZW-1:0];
         z_pitch_ff  <= prep_pitch[ZW-1:0];
         z_roll_ff   <= prep_roll[ZW-1:0];
         n_yaw_ff    <= prep_yaw[ZW];
         n_pitch_ff  <= prep_pitch[ZW];
         n_roll_ff   <= prep_roll[ZW];
      end
   end

   // Sine and cosine of the three goal angles
   logic signed [CW-1:0] sy, cy, sp, cp, sr, cr;

   gftc_cordic #(.ITERS(N)) u_cordic_yaw (
      .clock(clock), .stage_en(stage_en[N:1]), .z_in(z_yaw_ff), .neg_in(n_yaw_ff),
      .sin_out(sy), .cos_out(cy));
   gftc_cordic #(.ITERS(N)) u_cordic_pitch (
      .clock(clock), .stage_en(stage_en[N:1]), .z_in(z_pitch_ff), .neg_in(n_pitch_ff),
      .sin_out(sp), .cos_out(cp));
   gftc_cordic #(.ITERS(N)) u_cordic_roll (
      .clock(clock), .stage_en(stage_en[N:1]), .z_in(z_roll_ff), .neg_in(n_roll_ff),
      .sin_out(sr), .cos_out(cr));

   // Carry offsets and heading alongside the CORDIC stages
   carry_type carry_dly_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_carry
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (stage_en[1]) carry_dly_ff[0] <= carry_s0_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (stage_en[k+1]) carry_dly_ff[k] <= carry_dly_ff[k-1];
         end
      end
   end

   // P1: first products of the rotation matrix
   carry_type            carry_p1_ff;
   logic signed [32:0]   m00_p1_ff, m01_p1_ff, m12_p1_ff;
   logic signed [32:0]   cysp_ff, sysp_ff, sycr_ff, cycr_ff, sr_p1_ff, sp_p1_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_P1]) begin
         carry_p1_ff <= carry_dly_ff[N-1];
         m00_p1_ff   <= mul30(cy, cp);
         m01_p1_ff   <= mul30(sy, cp);
         m12_p1_ff   <= mul30(cp, sr);
         cysp_ff     <= mul30(cy, sp);
         sysp_ff     <= mul30(sy, sp);
         sycr_ff     <= mul30(sy, cr);
         cycr_ff     <= mul30(cy, cr);
         sr_p1_ff    <= sr;
         sp_p1_ff    <= sp;
      end
   end

   // P2: finish the matrix rows
   carry_type          carry_p2_ff;
   logic signed [32:0] m00_ff, m01_ff, m02_ff, m10_ff, m11_ff, m12_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_P2]) begin
         carry_p2_ff <= carry_p1_ff;
         m00_ff      <= m00_p1_ff;
         m01_ff      <= m01_p1_ff;
         m02_ff      <= -sp_p1_ff;
         m10_ff      <= mul30(cysp_ff, sr_p1_ff) - sycr_ff;
         m11_ff      <= mul30(sysp_ff, sr_p1_ff) + cycr_ff;
         m12_ff      <= m12_p1_ff;
      end
   end

   // P3: matrix times offset, each term rounded on its own
   logic signed [15:0] head_p3_ff;
   logic signed [35:0] tx0_ff, tx1_ff, tx2_ff, ty0_ff, ty1_ff, ty2_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_P3]) begin
         head_p3_ff <= carry_p2_ff.head;
         tx0_ff     <= term30(m00_ff, carry_p2_ff.dx);
         tx1_ff     <= term30(m01_ff, carry_p2_ff.dy);
         tx2_ff     <= term30(m02_ff, carry_p2_ff.dz);
         ty0_ff     <= term30(m10_ff, carry_p2_ff.dx);
         ty1_ff     <= term30(m11_ff, carry_p2_ff.dy);
         ty2_ff     <= term30(m12_ff, carry_p2_ff.dz);
      end
   end

   // P4: sum, status, saturate
   logic signed [37:0] gx_sum, gy_sum;
   logic signed [31:0] gx_sat, gy_sat;
   logic [1:0]         status_in;
   logic [1:0]         status_p4_ff;
   logic signed [31:0] err_p4_ff, gx_p4_ff;
   logic signed [15:0] head_p4_ff;

   always_comb begin
      gx_sum = 38'(tx0_ff) + 38'(tx1_ff) + 38'(tx2_ff);
      gy_sum = 38'(ty0_ff) + 38'(ty1_ff) + 38'(ty2_ff);
      if (gx_sum > 38'sh007fffffff) gx_sat = 32'sh7fffffff;
      else if (gx_sum < -38'sh0080000000) gx_sat = 32'sh80000000;
      else gx_sat = gx_sum[31:0];
      if (gy_sum > 38'sh007fffffff) gy_sat = 32'sh7fffffff;
      else if (gy_sum < -38'sh0080000000) gy_sat = 32'sh80000000;
      else gy_sat = gy_sum[31:0];
      priority if (18'(head_p3_ff) >= HALF_PI_Q13 || 18'(head_p3_ff) <= -HALF_PI_Q13)
         status_in = STATUS_BAD;
      else if (gx_sum >= 0)
         status_in = STATUS_CROSSED;
      else
         status_in = STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_P4]) begin
         status_p4_ff <= status_in;
         err_p4_ff    <= gy_sat;
         gx_p4_ff     <= gx_sat;
         head_p4_ff   <= head_p3_ff;
      end
   end

   // P5: gain products
   logic [1:0]         status_p5_ff;
   logic signed [31:0] err_p5_ff, gx_p5_ff;
   logic signed [15:0] head_p5_ff;
   logic signed [47:0] steer_lat_ff, speed_lat_ff;
   logic signed [34:0] steer_hdg_ff, speed_hdg_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_P5]) begin
         status_p5_ff <= status_p4_ff;
         err_p5_ff    <= err_p4_ff;
         gx_p5_ff     <= gx_p4_ff;
         head_p5_ff   <= head_p4_ff;
         steer_lat_ff <= 48'(steer_gain_lat_ff) * 48'(err_p4_ff);
         speed_lat_ff <= 48'(speed_gain_lat_ff) * 48'(err_p4_ff);
         steer_hdg_ff <= (35'(steer_gain_hdg_ff) * 35'(head_p4_ff)) <<< 3;
         speed_hdg_ff <= (35'(speed_gain_hdg_ff) * 35'(head_p4_ff)) <<< 3;
      end
   end

   // P6: steering round and saturate, speed adjustment magnitude
   logic signed [48:0] steer_sum, adj_sum;
   logic signed [40:0] steer_rnd;
   logic signed [31:0] steer_in;
   logic [48:0]        adj_round;
   logic [1:0]         status_p6_ff;
   logic signed [31:0] err_p6_ff, gx_p6_ff, steer_p6_ff;
   logic signed [15:0] head_p6_ff;
   logic [30:0]        red_num_ff;

   always_comb begin
      steer_sum = 49'(steer_lat_ff) + 49'(steer_hdg_ff);
      steer_rnd = 41'((steer_sum + 49'sd128) >>> 8);
      if (steer_rnd > 41'sh007fffffff) steer_in = 32'sh7fffffff;
      else if (steer_rnd < -41'sh0080000000) steer_in = 32'sh80000000;
      else steer_in = steer_rnd[31:0];
      adj_sum   = 49'(speed_lat_ff) + 49'(speed_hdg_ff);
      adj_round = (adj_sum < 0 ? -adj_sum : adj_sum) + RED_ROUND;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_P6]) begin
         status_p6_ff <= status_p5_ff;
         err_p6_ff    <= err_p5_ff;
         gx_p6_ff     <= gx_p5_ff;
         head_p6_ff   <= head_p5_ff;
         steer_p6_ff  <= steer_in;
         red_num_ff   <= adj_round[46:16];
      end
   end

   // P7: divide by fifty through the reciprocal
   logic [1:0]         status_p7_ff;
   logic signed [31:0] err_p7_ff, gx_p7_ff, steer_p7_ff;
   logic signed [15:0] head_p7_ff;
   logic [62:0]        red_prod_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_P7]) begin
         status_p7_ff <= status_p6_ff;
         err_p7_ff    <= err_p6_ff;
         gx_p7_ff     <= gx_p6_ff;
         head_p7_ff   <= head_p6_ff;
         steer_p7_ff  <= steer_p6_ff;
         red_prod_ff  <= 63'(red_num_ff) * 63'(RECIP_50);
      end
   end

   // Output stage: speed floor and response register; the reduction can reach 26 bits
   logic signed [27:0] speed_raw;
   logic signed [15:0] speed_in;
   rsp_type            rsp_ff;

   always_comb begin
      speed_raw = 28'(max_speed_ff) - $signed({2'b00, red_prod_ff[62:37]});
      if (speed_raw < 28'(base_speed_ff)) speed_raw = 28'(base_speed_ff);
      if (speed_raw > 28'sd32767) speed_in = 16'sh7fff;
      else if (speed_raw < -28'sd32768) speed_in = 16'sh8000;
      else speed_in = speed_raw[15:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         rsp_ff.status        <= status_p7_ff;
         rsp_ff.steering_cmd  <= steer_p7_ff;
         rsp_ff.speed_cmd     <= speed_in;
         rsp_ff.lateral_error <= err_p7_ff;
         rsp_ff.heading_error <= head_p7_ff;
         rsp_ff.along_goal_x  <= gx_p7_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

>>> rtl/gftc_checker.sv
module gftc_checker import gftc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response beat dropped or changed while stalled");

   // Drop all beats on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Bad orientation exactly when the heading error reaches a quarter turn
   a_status_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp.status == STATUS_BAD) ==
                     (18'(rsp.heading_error) >= HALF_PI_Q13 ||
                      18'(rsp.heading_error) <= -HALF_PI_Q13)))
      else $error("status does not match heading error");

   // Crossed goal only with a non-negative goal-frame x
   a_status_crossed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == STATUS_CROSSED |-> !rsp.along_goal_x[31])
      else $error("crossed goal with negative x");

endmodule

bind goal_frame_path_tracking_controller_core gftc_checker u_gftc_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp(rsp)
);
